[sv/qprot_pkg.sv]
package qprot_pkg;

    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    typedef enum logic [1:0] {
        FUNC_PRODUCT = 2'd0,
        FUNC_ROTATE  = 2'd1,
        FUNC_CONJ    = 2'd2
    } func_t;

    typedef logic [1:0] comp_idx_t;

    // hamilton product o = l*r: o[k] = sum over j of +/- l[HAM_IDX[k][j]] * r[j]
    // components ordered x, y, z, w
    localparam comp_idx_t HAM_IDX [4][4] = '{
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd3}
    };

    // bit j set: term j is subtracted
    localparam logic [3:0] HAM_NEG [4] = '{
        4'b0010,
        4'b0100,
        4'b0001,
        4'b0111
    };

endpackage

[sv/quaternion_product_rotate_unit.sv]
// Fixed-point quaternion unit: Hamilton product q*p (func 0), rotation of the vector
// (p_x,p_y,p_z) as q*v*conj(q) with r_w = 0 (func 1), or conjugate of q (func 2); the
// unused code returns all zeros. Components are signed with FRAC_BITS fraction bits,
// every sum of products is rounded to nearest and saturated, and saturated flags any
// clipping. The unit is a six-stage pipeline (products, sums, round, second products,
// sums, round): busy never goes high, one transfer is taken every cycle, and each result
// is shown on the result ports with done high for one cycle. Results cannot be held off,
// so the receiver must take them as they come.
module quaternion_product_rotate_unit #(
    parameter int COMP_WIDTH = qprot_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qprot_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   func,
    input  logic signed [COMP_WIDTH-1:0] q_x,
    input  logic signed [COMP_WIDTH-1:0] q_y,
    input  logic signed [COMP_WIDTH-1:0] q_z,
    input  logic signed [COMP_WIDTH-1:0] q_w,
    input  logic signed [COMP_WIDTH-1:0] p_x,
    input  logic signed [COMP_WIDTH-1:0] p_y,
    input  logic signed [COMP_WIDTH-1:0] p_z,
    input  logic signed [COMP_WIDTH-1:0] p_w,
    output logic                         done,
    output logic signed [COMP_WIDTH-1:0] r_x,
    output logic signed [COMP_WIDTH-1:0] r_y,
    output logic signed [COMP_WIDTH-1:0] r_z,
    output logic signed [COMP_WIDTH-1:0] r_w,
    output logic                         saturated
);

    import qprot_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int MW   = COMP_WIDTH + 4;           // rotation intermediate
    localparam int P1W  = 2 * CW;                   // first products
    localparam int P2W  = MW + CW + 1;              // second products
    localparam int S1W  = (2 * CW + 3 > FRAC_BITS + 2) ? 2 * CW + 3 : FRAC_BITS + 2;
    localparam int S2W  = (P2W + 3 > FRAC_BITS + 2) ? P2W + 3 : FRAC_BITS + 2;

    localparam logic signed [S1W-1:0] HALF1 = {{(S1W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [S2W-1:0] HALF2 = {{(S2W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [S1W-1:0] MAX1C = {{(S1W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [S1W-1:0] MIN1C = ~MAX1C;
    localparam logic signed [S1W-1:0] MAX1M = {{(S1W-MW+1){1'b0}}, {(MW-1){1'b1}}};
    localparam logic signed [S1W-1:0] MIN1M = ~MAX1M;
    localparam logic signed [S2W-1:0] MAX2C = {{(S2W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [S2W-1:0] MIN2C = ~MAX2C;
    localparam logic signed [CW-1:0]  CMAX  = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]  CMIN  = {1'b1, {(CW-1){1'b0}}};

    // stage a: first products
    logic                  a_valid_reg;
    logic [1:0]            a_func_reg;
    logic signed [CW-1:0]  a_q_reg    [4];
    logic signed [P1W-1:0] a_prod_reg [4][4];
    // stage b: first sums
    logic                  b_valid_reg;
    logic [1:0]            b_func_reg;
    logic signed [CW-1:0]  b_q_reg    [4];
    logic signed [S1W-1:0] b_sum_reg  [4];
    // stage c: rounded first result
    logic                  c_valid_reg;
    logic [1:0]            c_func_reg;
    logic signed [CW-1:0]  c_q_reg    [4];
    logic signed [MW-1:0]  c_res_reg  [4];
    logic                  c_flag_reg;
    // stage d: second products
    logic                  d_valid_reg;
    logic [1:0]            d_func_reg;
    logic signed [CW-1:0]  d_q_reg    [4];
    logic signed [MW-1:0]  d_res_reg  [4];
    logic                  d_flag_reg;
    logic signed [P2W-1:0] d_prod_reg [3][4];
    // stage e: second sums
    logic                  e_valid_reg;
    logic [1:0]            e_func_reg;
    logic signed [CW-1:0]  e_q_reg    [4];
    logic signed [MW-1:0]  e_res_reg  [4];
    logic                  e_flag_reg;
    logic signed [S2W-1:0] e_sum_reg  [3];
    // output register
    logic                  done_reg;
    logic [1:0]            f_func_reg;
    logic signed [CW-1:0]  r_reg      [4];
    logic                  sat_reg;

    logic signed [CW-1:0]  q_in       [4];
    logic signed [CW-1:0]  p_in       [4];
    logic signed [P1W-1:0] a_prod_next[4][4];
    logic signed [S1W-1:0] b_sum_next [4];
    logic signed [MW-1:0]  c_res_next [4];
    logic                  c_flag_next;
    logic signed [P2W-1:0] d_prod_next[3][4];
    logic signed [S2W-1:0] e_sum_next [3];
    logic signed [CW-1:0]  r_next     [4];
    logic                  sat_next;

    assign busy = 1'b0;

    assign q_in[0] = q_x;
    assign q_in[1] = q_y;
    assign q_in[2] = q_z;
    assign q_in[3] = q_w;
    assign p_in[0] = p_x;
    assign p_in[1] = p_y;
    assign p_in[2] = p_z;
    // vector has no scalar part when rotating
    assign p_in[3] = (func == FUNC_ROTATE) ? '0 : p_w;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                a_prod_next[k][j] = P1W'(q_in[HAM_IDX[k][j]]) * P1W'(p_in[j]);
            end
        end
    end

    always_comb
    begin
        logic signed [S1W-1:0] acc;
        logic signed [S1W-1:0] term;
        for (int k = 0; k < 4; k++)
        begin
            acc = '0;
            for (int j = 0; j < 4; j++)
            begin
                term = S1W'(a_prod_reg[k][j]);
                acc  = HAM_NEG[k][j] ? acc - term : acc + term;
            end
            b_sum_next[k] = acc;
        end
    end

    // round to nearest, saturate to the component width or the wider intermediate
    always_comb
    begin
        logic signed [S1W-1:0] rnd;
        logic signed [S1W-1:0] hi_lim;
        logic signed [S1W-1:0] lo_lim;
        c_flag_next = 1'b0;
        hi_lim = (b_func_reg == FUNC_ROTATE) ? MAX1M : MAX1C;
        lo_lim = (b_func_reg == FUNC_ROTATE) ? MIN1M : MIN1C;
        for (int k = 0; k < 4; k++)
        begin
            rnd = (b_sum_reg[k] + HALF1) >>> FRAC_BITS;
            if (rnd > hi_lim)
            begin
                c_res_next[k] = MW'(hi_lim);
                c_flag_next   = 1'b1;
            end
            else if (rnd < lo_lim)
            begin
                c_res_next[k] = MW'(lo_lim);
                c_flag_next   = 1'b1;
            end
            else
            begin
                c_res_next[k] = MW'(rnd);
            end
        end
    end

    // t * conj(q), conjugate taken exactly at one extra bit
    always_comb
    begin
        logic signed [CW:0] cq [4];
        for (int j = 0; j < 3; j++)
        begin
            cq[j] = -((CW+1)'(c_q_reg[j]));
        end
        cq[3] = (CW+1)'(c_q_reg[3]);
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                d_prod_next[k][j] = P2W'(c_res_reg[HAM_IDX[k][j]]) * P2W'(cq[j]);
            end
        end
    end

    always_comb
    begin
        logic signed [S2W-1:0] acc;
        logic signed [S2W-1:0] term;
        for (int k = 0; k < 3; k++)
        begin
            acc = '0;
            for (int j = 0; j < 4; j++)
            begin
                term = S2W'(d_prod_reg[k][j]);
                acc  = HAM_NEG[k][j] ? acc - term : acc + term;
            end
            e_sum_next[k] = acc;
        end
    end

    always_comb
    begin
        logic signed [S2W-1:0] rnd;
        logic                  rot_flag;
        logic                  conj_flag;
        logic signed [CW-1:0]  rot  [3];
        logic signed [CW-1:0]  conj [3];
        rot_flag  = 1'b0;
        conj_flag = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            rnd = (e_sum_reg[k] + HALF2) >>> FRAC_BITS;
            if (rnd > MAX2C)
            begin
                rot[k]   = CMAX;
                rot_flag = 1'b1;
            end
            else if (rnd < MIN2C)
            begin
                rot[k]   = CMIN;
                rot_flag = 1'b1;
            end
            else
            begin
                rot[k] = CW'(rnd);
            end
            // only the most negative value cannot be negated
            if (e_q_reg[k] == CMIN)
            begin
                conj[k]   = CMAX;
                conj_flag = 1'b1;
            end
            else
            begin
                conj[k] = -e_q_reg[k];
            end
        end
        case (e_func_reg)
            FUNC_PRODUCT:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    r_next[k] = CW'(e_res_reg[k]);
                end
                sat_next = e_flag_reg;
            end
            FUNC_ROTATE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    r_next[k] = rot[k];
                end
                r_next[3] = '0;
                sat_next  = e_flag_reg | rot_flag;
            end
            FUNC_CONJ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    r_next[k] = conj[k];
                end
                r_next[3] = e_q_reg[3];
                sat_next  = conj_flag;
            end
            default:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    r_next[k] = '0;
                end
                sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= start && !busy;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            done_reg    <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_func_reg  <= func;
        a_q_reg     <= q_in;
        a_prod_reg  <= a_prod_next;
        b_func_reg  <= a_func_reg;
        b_q_reg     <= a_q_reg;
        b_sum_reg   <= b_sum_next;
        c_func_reg  <= b_func_reg;
        c_q_reg     <= b_q_reg;
        c_res_reg   <= c_res_next;
        c_flag_reg  <= c_flag_next;
        d_func_reg  <= c_func_reg;
        d_q_reg     <= c_q_reg;
        d_res_reg   <= c_res_reg;
        d_flag_reg  <= c_flag_reg;
        d_prod_reg  <= d_prod_next;
        e_func_reg  <= d_func_reg;
        e_q_reg     <= d_q_reg;
        e_res_reg   <= d_res_reg;
        e_flag_reg  <= d_flag_reg;
        e_sum_reg   <= e_sum_next;
        f_func_reg  <= e_func_reg;
        r_reg       <= r_next;
        sat_reg     <= sat_next;
    end

    assign done      = done_reg;
    assign r_x       = r_reg[0];
    assign r_y       = r_reg[1];
    assign r_z       = r_reg[2];
    assign r_w       = r_reg[3];
    assign saturated = sat_reg;

    // every accepted transfer comes out as a result with done high
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted item did not complete after six cycles");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without a matching transfer");

    a_func_align: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> f_func_reg == $past(func, 6))
        else $error("operation code misaligned in pipeline");

    a_conj_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (done && f_func_reg == FUNC_CONJ) |-> r_w == $past(q_w, 6))
        else $error("conjugate scalar part does not match its input");

endmodule

[sim/quaternion_product_checker.sv]
module quaternion_product_checker #(
    parameter int COMP_WIDTH = qprot_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qprot_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   func,
    input  logic signed [COMP_WIDTH-1:0] q_x,
    input  logic signed [COMP_WIDTH-1:0] q_y,
    input  logic signed [COMP_WIDTH-1:0] q_z,
    input  logic signed [COMP_WIDTH-1:0] q_w,
    input  logic signed [COMP_WIDTH-1:0] p_x,
    input  logic signed [COMP_WIDTH-1:0] p_y,
    input  logic signed [COMP_WIDTH-1:0] p_z,
    input  logic signed [COMP_WIDTH-1:0] p_w,
    input  logic                         done,
    input  logic signed [COMP_WIDTH-1:0] r_x,
    input  logic signed [COMP_WIDTH-1:0] r_y,
    input  logic signed [COMP_WIDTH-1:0] r_z,
    input  logic signed [COMP_WIDTH-1:0] r_w,
    input  logic                         saturated,
    output int                           failures,
    output int                           pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import qprot_pkg::*;

    localparam int MID_WIDTH = COMP_WIDTH + 4;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef longint quad_t [4];

    typedef struct packed {
        logic [1:0] op;
        comp_t      x;
        comp_t      y;
        comp_t      z;
        comp_t      w;
        logic       sat;
    } quat_result_t;

    quat_result_t results_due [$];
    quat_result_t due;
    quat_result_t got;
    quad_t        q_in;
    quad_t        p_in;

    // round half up, then clip to a signed width
    function automatic longint round_clip(longint acc, int width, inout logic clip);
        longint lim_hi;
        longint lim_lo;
        longint v;
        lim_hi = (longint'(1) <<< (width - 1)) - 1;
        lim_lo = -lim_hi - 1;
        v = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (v > lim_hi)
        begin
            clip = 1'b1;
            v = lim_hi;
        end
        else if (v < lim_lo)
        begin
            clip = 1'b1;
            v = lim_lo;
        end
        return v;
    endfunction

    // one component of the hamilton product l*r, order x, y, z, w
    function automatic longint hamilton_comp(quad_t l, quad_t r, int k, int width,
                                             inout logic clip);
        longint acc;
        case (k)
            0: acc = l[3] * r[0] - l[2] * r[1] + l[1] * r[2] + l[0] * r[3];
            1: acc = l[2] * r[0] + l[3] * r[1] - l[0] * r[2] + l[1] * r[3];
            2: acc = -l[1] * r[0] + l[0] * r[1] + l[3] * r[2] + l[2] * r[3];
            default: acc = -l[0] * r[0] - l[1] * r[1] - l[2] * r[2] + l[3] * r[3];
        endcase
        return round_clip(acc, width, clip);
    endfunction

    function automatic comp_t negate_clip(longint v, inout logic clip);
        longint lim_hi;
        lim_hi = (longint'(1) <<< (COMP_WIDTH - 1)) - 1;
        if (-v > lim_hi)
        begin
            clip = 1'b1;
            return comp_t'(lim_hi);
        end
        return comp_t'(-v);
    endfunction

    function automatic quat_result_t predict_quat(logic [1:0] op, quad_t q, quad_t p);
        quat_result_t res;
        quad_t        t;
        quad_t        cq;
        logic         clip;
        res = '0;
        clip = 1'b0;
        res.op = op;
        case (op)
            FUNC_PRODUCT:
            begin
                res.x = comp_t'(hamilton_comp(q, p, 0, COMP_WIDTH, clip));
                res.y = comp_t'(hamilton_comp(q, p, 1, COMP_WIDTH, clip));
                res.z = comp_t'(hamilton_comp(q, p, 2, COMP_WIDTH, clip));
                res.w = comp_t'(hamilton_comp(q, p, 3, COMP_WIDTH, clip));
            end
            FUNC_ROTATE:
            begin
                p[3] = 0;
                for (int k = 0; k < 4; k++)
                    t[k] = hamilton_comp(q, p, k, MID_WIDTH, clip);
                // exact conjugate, no clipping of -q here
                cq = '{-q[0], -q[1], -q[2], q[3]};
                res.x = comp_t'(hamilton_comp(t, cq, 0, COMP_WIDTH, clip));
                res.y = comp_t'(hamilton_comp(t, cq, 1, COMP_WIDTH, clip));
                res.z = comp_t'(hamilton_comp(t, cq, 2, COMP_WIDTH, clip));
            end
            FUNC_CONJ:
            begin
                res.x = negate_clip(q[0], clip);
                res.y = negate_clip(q[1], clip);
                res.z = negate_clip(q[2], clip);
                res.w = comp_t'(q[3]);
            end
            default: ;
        endcase
        res.sat = clip;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_due.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // result leaving the unit is checked before the new transfer is queued
            if (done === 1'b1)
            begin
                got = '{op: 2'b00, x: r_x, y: r_y, z: r_z, w: r_w, sat: saturated};
                if (results_due.size() == 0)
                begin
                    if (failures < 10)
                        $display({"%0t: result with nothing outstanding: ",
                                  "x=%0d y=%0d z=%0d w=%0d sat=%0b"},
                                 $realtime, r_x, r_y, r_z, r_w, saturated);
                    failures <= failures + 1;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (got.x !== due.x || got.y !== due.y || got.z !== due.z ||
                        got.w !== due.w || got.sat !== due.sat)
                    begin
                        if (failures < 10)
                            $display({"%0t: func %0d mismatch: expected x=%0d y=%0d z=%0d w=%0d ",
                                      "sat=%0b, got x=%0d y=%0d z=%0d w=%0d sat=%0b"},
                                     $realtime, due.op, due.x, due.y, due.z, due.w, due.sat,
                                     got.x, got.y, got.z, got.w, got.sat);
                        failures <= failures + 1;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                q_in = '{longint'(q_x), longint'(q_y), longint'(q_z), longint'(q_w)};
                p_in = '{longint'(p_x), longint'(p_y), longint'(p_z), longint'(p_w)};
                results_due.push_back(predict_quat(func, q_in, p_in));
            end
            pending <= results_due.size();
        end
    end

endmodule

[sim/tb_quaternion_product_rotate_unit.sv]
module tb_quaternion_product_rotate_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import qprot_pkg::*;

    localparam int         COMP_WIDTH  = COMP_WIDTH_DEF;
    localparam int         CYCLE_LIMIT = 100000;
    localparam int         DRAIN_WAIT  = 12;
    localparam int         RAND_ITEMS  = 930;
    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         IDLE_PCT [3] = '{0, 68, 20};

    typedef logic signed [COMP_WIDTH-1:0] comp_t;

    localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
    localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};
    localparam comp_t ONE      = comp_t'(1 << FRAC_BITS_DEF);
    localparam comp_t HALF_SQ2 = comp_t'(11585);

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] func;
    comp_t      q_x, q_y, q_z, q_w;
    comp_t      p_x, p_y, p_z, p_w;
    logic       done;
    comp_t      r_x, r_y, r_z, r_w;
    logic       saturated;
    int         failures;
    int         pending;
    int         idle_pct;
    int         cycles;

    quaternion_product_rotate_unit uut (.*);

    quaternion_product_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic comp_t rand_comp(bit near_unit);
        if (near_unit)
            return comp_t'(int'($urandom_range(0, 16384)) - 8192);
        case ($urandom_range(0, 7))
            0: return COMP_MIN;
            1: return COMP_MAX;
            2: return comp_t'(int'($urandom_range(0, 64)) - 32);
            default: return comp_t'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] rand_func();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8)
            return FUNC_PRODUCT;
        else if (pick < 15)
            return FUNC_ROTATE;
        else if (pick < 19)
            return FUNC_CONJ;
        return FUNC_SPARE;
    endfunction

    task automatic scramble_fields();
        func = 2'($urandom);
        {q_x, q_y, q_z, q_w} = {$urandom, $urandom};
        {p_x, p_y, p_z, p_w} = {$urandom, $urandom};
    endtask

    // called at a falling edge, returns at a falling edge after the transfer and any idle gaps
    task automatic issue_quat(logic [1:0] op, comp_t qx, comp_t qy, comp_t qz, comp_t qw,
                              comp_t px, comp_t py, comp_t pz, comp_t pw);
        func  = op;
        q_x   = qx;
        q_y   = qy;
        q_z   = qz;
        q_w   = qw;
        p_x   = px;
        p_y   = py;
        p_z   = pz;
        p_w   = pw;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start = 1'b0;
            scramble_fields();
            @(negedge clk);
        end
    endtask

    task automatic issue_random();
        bit near_unit;
        near_unit = 1'($urandom_range(0, 1));
        issue_quat(rand_func(), rand_comp(near_unit), rand_comp(near_unit),
                   rand_comp(near_unit), rand_comp(near_unit), rand_comp(near_unit),
                   rand_comp(near_unit), rand_comp(near_unit), rand_comp(near_unit));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        func     = FUNC_PRODUCT;
        q_x      = '0;
        q_y      = '0;
        q_z      = '0;
        q_w      = '0;
        p_x      = '0;
        p_y      = '0;
        p_z      = '0;
        p_w      = '0;
        cycles   = 0;
        idle_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, identities, every func, rounding ties
        issue_quat(FUNC_PRODUCT, '0, '0, '0, '0, '0, '0, '0, '0);
        issue_quat(FUNC_PRODUCT, '0, '0, '0, ONE, comp_t'(1234), comp_t'(-4321),
                   comp_t'(9999), comp_t'(-16384));
        issue_quat(FUNC_PRODUCT, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                   COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        issue_quat(FUNC_PRODUCT, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                   COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        issue_quat(FUNC_PRODUCT, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN,
                   COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX);
        // half-lsb ties go up, both signs
        issue_quat(FUNC_PRODUCT, '0, '0, '0, comp_t'(1), '0, '0, '0, comp_t'(8192));
        issue_quat(FUNC_PRODUCT, '0, '0, '0, comp_t'(1), '0, '0, '0, comp_t'(-8192));
        issue_quat(FUNC_ROTATE, '0, '0, '0, ONE, ONE, -ONE, comp_t'(8192), '0);
        // quarter turn about z
        issue_quat(FUNC_ROTATE, '0, '0, HALF_SQ2, HALF_SQ2, ONE, '0, '0, '0);
        issue_quat(FUNC_ROTATE, '0, '0, HALF_SQ2, HALF_SQ2, ONE, '0, '0, COMP_MAX);
        issue_quat(FUNC_ROTATE, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                   COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        issue_quat(FUNC_ROTATE, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                   COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
        issue_quat(FUNC_ROTATE, COMP_MIN, COMP_MAX, '0, COMP_MIN, COMP_MAX, COMP_MIN, ONE, '0);
        issue_quat(FUNC_CONJ, comp_t'(100), comp_t'(-200), comp_t'(300), comp_t'(-400),
                   COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
        issue_quat(FUNC_CONJ, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, '0, '0, '0, '0);
        issue_quat(FUNC_CONJ, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, '0, '0, '0, '0);
        issue_quat(FUNC_CONJ, '0, COMP_MIN, '0, COMP_MAX, '0, '0, '0, '0);
        issue_quat(FUNC_SPARE, ONE, -ONE, COMP_MAX, COMP_MIN, ONE, COMP_MAX, COMP_MIN, ONE);
        issue_quat(FUNC_SPARE, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                   COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_pct = IDLE_PCT[ph];
            for (int n = 0; n < RAND_ITEMS / 3; n++)
                issue_random();
        end
        start = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/qprot_pkg.sv
sv/quaternion_product_rotate_unit.sv
sim/quaternion_product_checker.sv
sim/tb_quaternion_product_rotate_unit.sv
